FILE: hw/rtl/lru_buffer_cache_tag_table_assert.svh
// Assertion macros used by the checker of the buffer cache tag table.
// Depends on nothing; the including file supplies clock, reset and signal names.
`ifndef LRU_BUFFER_CACHE_TAG_TABLE_ASSERT_SVH
`define LRU_BUFFER_CACHE_TAG_TABLE_ASSERT_SVH
// Same-cycle implication, disabled while reset is high.
`define LBCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define LBCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: hw/rtl/lbct_pkg.sv
// Shared types, codes and width helpers for the buffer cache tag table.
// Used by the entry cell, the top level and the checker; depends on nothing.
`default_nettype none

package lbct_pkg;

   // Default sizes and the fixed field widths of the request and response words.
   localparam int NUM_ENTRIES_DEF = 32;
   localparam int COUNT_BITS_DEF  = 8;
   localparam int DEVICE_W        = 4;
   localparam int BLOCK_W         = 20;
   localparam int INDEX_W         = 5;
   localparam int TICK_W          = 32;

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_UNPIN   = 2'd3
   } opcode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFREE = 2'd1,
      ST_UNDER  = 2'd2,
      ST_SAT    = 2'd3
   } status_type;

   // Write commands broadcast from the controller to the selected cell.
   typedef enum logic [2:0] {
      UPD_NONE    = 3'd0,
      UPD_RETAG   = 3'd1,
      UPD_HIT     = 3'd2,
      UPD_INC     = 3'd3,
      UPD_DEC     = 3'd4,
      UPD_RELEASE = 3'd5
   } upd_op_type;

   // Broadcast bus: the write command plus the tags and tick of the current request.
   typedef struct packed {
      upd_op_type          op;
      logic [DEVICE_W-1:0] device;
      logic [BLOCK_W-1:0]  block;
      logic [TICK_W-1:0]   tick;
   } upd_type;

   // Width of an entry index for a table of n entries.
   function automatic int index_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // Width of the search word handed from cell to cell.
   function automatic int carry_width(input int idx_w, input int count_bits);
      return 4 + 2 * idx_w + count_bits + TICK_W;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lbct_cell.sv
// One entry of the buffer cache tag table: tags, count, tick and data-valid mark,
// plus one registered stage of the search chain. Depends on lbct_pkg.
`default_nettype none

module lbct_cell
   import lbct_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int IDX_W      = index_width(NUM_ENTRIES_DEF),
   parameter int INDEX      = 0,
   localparam int CARRY_W   = carry_width(IDX_W, COUNT_BITS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CARRY_W-1:0]    prev_carry,
   output logic      [CARRY_W-1:0]    next_carry,
   input  wire upd_type               upd,
   input  wire logic                  upd_sel,
   output logic      [COUNT_BITS-1:0] count
);

   // Search word: first tag match so far and oldest free entry so far.
   typedef struct packed {
      logic                  live;
      logic                  hit;
      logic [IDX_W-1:0]      hit_idx;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  hit_valid;
      logic                  vic;
      logic [IDX_W-1:0]      vic_idx;
      logic [TICK_W-1:0]     vic_tick;
   } carry_type;

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic [DEVICE_W-1:0]   device_ff, device_in;
   logic [BLOCK_W-1:0]    block_ff, block_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic                  valid_ff, valid_in;
   carry_type             carry_ff, carry_in;
   carry_type             cin;
   logic                  match;

   assign cin   = carry_type'(prev_carry);
   assign match = (device_ff == upd.device) && (block_ff == upd.block);

   // Fold this entry into the search word: lower indexes keep priority on ties.
   always_comb begin
      carry_in = cin;
      if (!cin.hit && match) begin
         carry_in.hit       = 1'b1;
         carry_in.hit_idx   = MY_INDEX;
         carry_in.hit_count = count_ff;
         carry_in.hit_valid = valid_ff;
      end
      if ((count_ff == '0) && (!cin.vic || (tick_ff < cin.vic_tick))) begin
         carry_in.vic      = 1'b1;
         carry_in.vic_idx  = MY_INDEX;
         carry_in.vic_tick = tick_ff;
      end
   end

   // Apply a write command when this entry is the selected one.
   always_comb begin
      device_in = device_ff;
      block_in  = block_ff;
      count_in  = count_ff;
      tick_in   = tick_ff;
      valid_in  = valid_ff;
      if (upd_sel) begin
         case (upd.op)
            UPD_RETAG: begin
               device_in = upd.device;
               block_in  = upd.block;
               count_in  = COUNT_BITS'(1);
               valid_in  = 1'b1;
            end
            UPD_HIT: begin
               count_in = count_ff + 1'b1;
               valid_in = 1'b1;
            end
            UPD_INC: begin
               count_in = count_ff + 1'b1;
            end
            UPD_DEC: begin
               count_in = count_ff - 1'b1;
            end
            UPD_RELEASE: begin
               count_in = count_ff - 1'b1;
               if (count_ff == COUNT_BITS'(1)) begin
                  tick_in = upd.tick;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Entry state and chain stage; the whole table clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_ff <= '0;
         block_ff  <= '0;
         count_ff  <= '0;
         tick_ff   <= '0;
         valid_ff  <= 1'b0;
         carry_ff  <= '0;
      end else begin
         device_ff <= device_in;
         block_ff  <= block_in;
         count_ff  <= count_in;
         tick_ff   <= tick_in;
         valid_ff  <= valid_in;
         carry_ff  <= carry_in;
      end
   end

   assign next_carry = CARRY_W'(carry_ff);
   assign count      = count_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lru_buffer_cache_tag_table.sv
// Buffer cache tag table with reference counts and least-recently-used replacement.
// A get request sends a search word down a row of NUM_ENTRIES entry cells, one cell
// per clock, which picks the lowest-index tag match and the oldest free entry (count
// zero, lowest index on equal ticks). The response word of a get is taken from the
// end of the cell chain into the pending result and then into the output register;
// release, pin and unpin address one entry directly and skip the cell chain. One
// request is in flight at a time; the next one is accepted once the previous response
// has been loaded into the output register, even if that word has not yet been taken.
// All entries clear at reset, with no clearing pass.
// Depends on lbct_pkg and lbct_cell.
`default_nettype none

module lru_buffer_cache_tag_table
   import lbct_pkg::*;
#(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [DEVICE_W-1:0] req_device,
   input  wire logic [BLOCK_W-1:0]  req_block_number,
   input  wire logic [INDEX_W-1:0]  req_entry_index,
   input  wire logic [TICK_W-1:0]   req_now_tick,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [INDEX_W-1:0]       rsp_result_index,
   output logic                     rsp_hit,
   output logic                     rsp_needs_read,
   output logic [1:0]               rsp_status
);

   localparam int IDX_W   = index_width(NUM_ENTRIES);
   localparam int CARRY_W = carry_width(IDX_W, COUNT_BITS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Same layout as the search word inside the cells.
   typedef struct packed {
      logic                  live;
      logic                  hit;
      logic [IDX_W-1:0]      hit_idx;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  hit_valid;
      logic                  vic;
      logic [IDX_W-1:0]      vic_idx;
      logic [TICK_W-1:0]     vic_tick;
   } carry_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SWEEP = 4'b0010,
      S_EXEC  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic                  start_ff, start_in;
   opcode_type            op_ff;
   logic [DEVICE_W-1:0]   device_ff;
   logic [BLOCK_W-1:0]    block_ff;
   logic [INDEX_W-1:0]    index_ff;
   logic [TICK_W-1:0]     tick_ff;
   logic [INDEX_W-1:0]    res_index_ff, res_index_in;
   logic                  res_hit_ff, res_hit_in;
   logic                  res_read_ff, res_read_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_read_ff, rsp_read_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic [CARRY_W-1:0]    chain [NUM_ENTRIES+1];
   carry_type             head;
   carry_type             last;
   logic [COUNT_BITS-1:0] count_vec [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] upd_sel;
   upd_op_type            upd_op;
   logic [IDX_W-1:0]      upd_idx;
   upd_type               upd;
   logic [IDX_W-1:0]      sel_index;
   logic                  in_range;
   logic [COUNT_BITS-1:0] sel_count;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // The search word enters the first cell the cycle after a get is accepted.
   always_comb begin
      head      = '0;
      head.live = start_ff;
   end
   assign chain[0] = CARRY_W'(head);
   assign last     = carry_type'(chain[NUM_ENTRIES]);

   // Write command bus shared by all cells.
   assign upd.op     = upd_op;
   assign upd.device = device_ff;
   assign upd.block  = block_ff;
   assign upd.tick   = tick_ff;

   // Row of entry cells.
   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      assign upd_sel[i] = (upd_idx == IDX_W'(i));
      lbct_cell #(
         .COUNT_BITS (COUNT_BITS),
         .IDX_W      (IDX_W),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_carry (chain[i]),
         .next_carry (chain[i+1]),
         .upd        (upd),
         .upd_sel    (upd_sel[i]),
         .count      (count_vec[i])
      );
   end

   // Direct entry access for release, pin and unpin.
   assign sel_index = IDX_W'(index_ff);
   assign in_range  = (int'(index_ff) < NUM_ENTRIES);
   assign sel_count = in_range ? count_vec[sel_index] : '0;

   // Request sequencing, decision and response handoff.
   always_comb begin
      state_in      = state_ff;
      start_in      = 1'b0;
      upd_op        = UPD_NONE;
      upd_idx       = '0;
      res_index_in  = res_index_ff;
      res_hit_in    = res_hit_ff;
      res_read_in   = res_read_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (opcode_type'(req_opcode) == OP_GET) begin
                  state_in = S_SWEEP;
                  start_in = 1'b1;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SWEEP: begin
            if (last.live) begin
               state_in = S_DONE;
               if (last.hit) begin
                  res_index_in = INDEX_W'(last.hit_idx);
                  res_hit_in   = 1'b1;
                  if (last.hit_count == COUNT_MAX) begin
                     res_read_in   = 1'b0;
                     res_status_in = ST_SAT;
                  end else begin
                     upd_op        = UPD_HIT;
                     upd_idx       = last.hit_idx;
                     res_read_in   = !last.hit_valid;
                     res_status_in = ST_OK;
                  end
               end else if (last.vic) begin
                  upd_op        = UPD_RETAG;
                  upd_idx       = last.vic_idx;
                  res_index_in  = INDEX_W'(last.vic_idx);
                  res_hit_in    = 1'b0;
                  res_read_in   = 1'b1;
                  res_status_in = ST_OK;
               end else begin
                  res_index_in  = '0;
                  res_hit_in    = 1'b0;
                  res_read_in   = 1'b0;
                  res_status_in = ST_NOFREE;
               end
            end
         end
         S_EXEC: begin
            state_in      = S_DONE;
            res_index_in  = index_ff;
            res_hit_in    = 1'b0;
            res_read_in   = 1'b0;
            res_status_in = ST_OK;
            if (in_range) begin
               upd_idx = sel_index;
               if (op_ff == OP_PIN) begin
                  if (sel_count == COUNT_MAX) begin
                     res_status_in = ST_SAT;
                  end else begin
                     upd_op = UPD_INC;
                  end
               end else if (sel_count == '0) begin
                  res_status_in = ST_UNDER;
               end else begin
                  upd_op = (op_ff == OP_RELEASE) ? UPD_RELEASE : UPD_DEC;
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_index_ff;
               rsp_hit_in    = res_hit_ff;
               rsp_read_in   = res_read_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request word capture.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= opcode_type'(req_opcode);
         device_ff <= req_device;
         block_ff  <= req_block_number;
         index_ff  <= req_entry_index;
         tick_ff   <= req_now_tick;
      end
   end

   // Pending result and output register.
   always_ff @(posedge clock) begin
      res_index_ff  <= res_index_in;
      res_hit_ff    <= res_hit_in;
      res_read_ff   <= res_read_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_needs_read   = rsp_read_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lbct_checker.sv
// Port-level checks for the buffer cache tag table, bound to the top level.
// Depends on lbct_pkg and lru_buffer_cache_tag_table_assert.svh.
`default_nettype none

`include "lru_buffer_cache_tag_table_assert.svh"

module lbct_checker
   import lbct_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [INDEX_W-1:0] rsp_result_index,
   input wire logic               rsp_hit,
   input wire logic               rsp_needs_read,
   input wire logic [1:0]         rsp_status
);

   // A stalled response word holds.
   `LBCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_index) && $stable(rsp_hit) && $stable(rsp_needs_read) && $stable(rsp_status), "response word changed while stalled")

   // One request at a time, and never answered in the cycle after acceptance.
   `LBCT_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready && !$rose(rsp_valid), "request overlap or early response")

   // A failed allocation reports nothing else.
   `LBCT_ASSERT_NOW(a_nofree_clean, clock, reset, rsp_valid && (rsp_status == ST_NOFREE), !rsp_hit && !rsp_needs_read && (rsp_result_index == '0), "no-free response carries data")

   // A disk read is only requested by a successful get.
   `LBCT_ASSERT_NOW(a_read_ok_only, clock, reset, rsp_valid && rsp_needs_read, rsp_status == ST_OK, "read requested on failed request")

endmodule

bind lru_buffer_cache_tag_table lbct_checker u_lbct_checker (.*);

`default_nettype wire
